[hw/rtl/itar_pkg.sv]
// Shared types, constants and helpers for the integer to ASCII converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itar_pkg;

	localparam int BASE_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
	localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX_NUM = DIGIT_W'(9);

	// status from the serial divider to the sequencer
	typedef struct packed {
		logic done;
		logic nonzero;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d > DIGIT_MAX_NUM) begin
			return dx - CHAR_W'(10) + ASCII_LOWER_A;
		end
		return dx + ASCII_ZERO;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/itar_in_if.sv]
// Input channel: one integer and its radix per word.
// Depends on itar_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface itar_in_if #(
	parameter int VALUE_WIDTH = 32
) ();
	logic                        valid;
	logic                        ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic [itar_pkg::BASE_W-1:0] base;

	modport source (output valid, output value, output base, input ready);
	modport sink (input valid, input value, input base, output ready);
endinterface

`default_nettype wire

[hw/rtl/itar_out_if.sv]
// Output channel: one ASCII character per word.
// Depends on itar_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface itar_out_if ();
	logic                        valid;
	logic                        ready;
	logic [itar_pkg::CHAR_W-1:0] digit_char;
	logic                        last;
	logic                        bad_base;

	modport source (output valid, output digit_char, output last, output bad_base,
		input ready);
	modport sink (input valid, input digit_char, input last, input bad_base,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/itar_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Gives the next digit (remainder) and the quotient. Depends on itar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itar_divider #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [VALUE_WIDTH-1:0]        dividend,
	input  wire [itar_pkg::BASE_W-1:0]   base,
	output itar_pkg::div_stat_t          stat,
	output logic [VALUE_WIDTH-1:0]       quotient,
	output logic [itar_pkg::DIGIT_W-1:0] remainder
);
	import itar_pkg::*;

	localparam int CW = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic                   nz_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] q_q;
	logic [DIGIT_W-1:0]     r_q;

	logic [DIGIT_W:0] shifted;
	logic             ge;
	logic [DIGIT_W:0] diff;

	// remainder stays below base, so one compare and subtract per bit
	assign shifted = {r_q, q_q[VALUE_WIDTH-1]};
	assign ge = shifted >= {1'b0, base};
	assign diff = shifted - {1'b0, base};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			nz_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				nz_q <= 1'b0;
				cnt_q <= CW'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				nz_q <= nz_q | ge;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_WIDTH-2:0], ge};
			r_q <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
		end
	end

	// done is the upper field of the status word
	assign stat = {done_q, nz_q};
	assign quotient = q_q;
	assign remainder = r_q;

endmodule

`default_nettype wire

[hw/rtl/itar_digit_buf.sv]
// Digit store: one write port, one registered read port.
// Depends on itar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itar_digit_buf #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               wr_en,
	input  wire [$clog2(VALUE_WIDTH)-1:0]     wr_addr,
	input  wire [itar_pkg::DIGIT_W-1:0]       wr_data,
	input  wire [$clog2(VALUE_WIDTH)-1:0]     rd_addr,
	output logic [itar_pkg::DIGIT_W-1:0]      rd_data
);
	import itar_pkg::*;

	logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
	logic [DIGIT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[hw/rtl/integer_to_ascii_radix.sv]
// Integer to ASCII digits in radix 2 to 36; top level with the sequencer.
// Depends on itar_pkg, itar_in_if, itar_out_if, itar_divider, itar_digit_buf.
//
// Usage:
//   num : valid/ready channel, one word = signed value plus radix.
//   chr : valid/ready channel, one word per ASCII character, most significant
//         digit first, last set on the final one. Base 10 negatives start
//         with '-'; other radixes print the unsigned bit pattern. A radix
//         outside 2..36 gives one word with bad_base set and character zero.
//   One number is handled at a time; num.ready is high only when idle.
//   Each digit is one pass of the bit-serial divider, and each character
//   then goes through the digit store read port (S_READ, S_LOAD, S_SHOW);
//   a sign adds S_SIGN. At width 32 radix 2 gives up to 32 digits, and a
//   radix 10 number has at most 10 digits and a sign.
//   When chr.ready is low the current character holds; nothing is dropped.
//   Reset returns the sequencer to idle with no word pending; the digit
//   store needs no clearing since every entry read was written first.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	itar_in_if.sink    num,
	itar_out_if.source chr
);
	import itar_pkg::*;

	localparam int AW = $clog2(VALUE_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SIGN,
		S_READ,
		S_LOAD,
		S_SHOW
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      idx_q;
	logic [BASE_W-1:0]  base_q;
	logic               neg_q;
	logic               valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               bad_q;

	logic                   accept;
	logic                   base_bad;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [BASE_W-1:0]      div_base;
	div_stat_t              div_stat;
	logic [VALUE_WIDTH-1:0] quotient;
	logic [DIGIT_W-1:0]     remainder;
	logic                   wr_en;
	logic [DIGIT_W-1:0]     rd_data;

	assign num.ready = (state_q == S_IDLE);
	assign accept = num.valid && (state_q == S_IDLE);
	assign base_bad = (num.base < BASE_MIN) || (num.base > BASE_MAX);
	assign raw = num.value;
	assign neg_in = raw[VALUE_WIDTH-1] && (num.base == BASE_DEC);
	// two's complement negate is exact for the most negative value too
	assign mag = neg_in ? (~raw + 1'b1) : raw;

	assign div_start = (accept && !base_bad)
		|| (state_q == S_DIV && div_stat.done && div_stat.nonzero);
	assign div_dividend = (state_q == S_IDLE) ? mag : quotient;
	assign div_base = (state_q == S_IDLE) ? num.base : base_q;
	assign wr_en = (state_q == S_DIV) && div_stat.done;

	itar_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.base     (div_base),
		.stat     (div_stat),
		.quotient (quotient),
		.remainder(remainder)
	);

	itar_digit_buf #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_q),
		.wr_data(remainder),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			base_q <= '0;
			neg_q <= 1'b0;
			valid_q <= 1'b0;
			char_q <= '0;
			last_q <= 1'b0;
			bad_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						base_q <= num.base;
						neg_q <= neg_in;
						if (base_bad) begin
							valid_q <= 1'b1;
							char_q <= '0;
							last_q <= 1'b1;
							bad_q <= 1'b1;
							state_q <= S_SHOW;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (div_stat.nonzero) begin
							idx_q <= idx_q + 1'b1;
						end else if (neg_q) begin
							valid_q <= 1'b1;
							char_q <= ASCII_MINUS;
							last_q <= 1'b0;
							bad_q <= 1'b0;
							state_q <= S_SIGN;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_SIGN: begin
					if (chr.ready) begin
						valid_q <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// store output registers mem[idx_q] at this edge
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					valid_q <= 1'b1;
					char_q <= digit_to_ascii(rd_data);
					last_q <= (idx_q == '0);
					bad_q <= 1'b0;
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (chr.ready) begin
						valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign chr.valid = valid_q;
	assign chr.digit_char = char_q;
	assign chr.last = last_q;
	assign chr.bad_base = bad_q;

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for integer_to_ascii_radix: drives numbers and radixes, checks every character word.
// Depends on itar_pkg, itar_in_if, itar_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
	import itar_pkg::*;

	localparam int VALUE_WIDTH = 32;
	localparam int RANDOM_ITEMS = 286;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 1200;
	localparam logic signed [VALUE_WIDTH-1:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_WIDTH-1:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} char_word_t;

	class digit_scoreboard;
		char_word_t expected_chars[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Work out the character words one number must produce.
		function void note_number(logic signed [VALUE_WIDTH-1:0] value,
				logic [BASE_W-1:0] base);
			logic [VALUE_WIDTH-1:0] mag;
			logic [VALUE_WIDTH-1:0] radix;
			logic [DIGIT_W-1:0] digits[$];
			logic neg;
			char_word_t w;
			if (base < BASE_MIN || base > BASE_MAX) begin
				w.ch = '0;
				w.last = 1'b1;
				w.bad = 1'b1;
				expected_chars.push_back(w);
				return;
			end
			radix = VALUE_WIDTH'(base);
			neg = value[VALUE_WIDTH-1] && (base == BASE_DEC);
			// negating the most negative value wraps to 2^31, which is the right magnitude
			mag = neg ? -value : value;
			if (mag == '0) begin
				digits.push_back('0);
			end
			while (mag != '0) begin
				digits.push_back(DIGIT_W'(mag % radix));
				mag = mag / radix;
			end
			if (neg) begin
				w.ch = ASCII_MINUS;
				w.last = 1'b0;
				w.bad = 1'b0;
				expected_chars.push_back(w);
			end
			for (int i = digits.size() - 1; i >= 0; i--) begin
				if (digits[i] < DIGIT_W'(10)) begin
					w.ch = ASCII_ZERO + CHAR_W'(digits[i]);
				end else begin
					w.ch = ASCII_LOWER_A + CHAR_W'(digits[i]) - CHAR_W'(10);
				end
				w.last = (i == 0);
				w.bad = 1'b0;
				expected_chars.push_back(w);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] ch, logic last, logic bad);
			char_word_t w;
			if (expected_chars.size() == 0) begin
				$error("unexpected word: digit_char %0h last %0b bad_base %0b", ch, last, bad);
				errors++;
				return;
			end
			w = expected_chars.pop_front();
			if (ch !== w.ch) begin
				$error("digit_char: expected %0h, got %0h", w.ch, ch);
				errors++;
			end
			if (last !== w.last) begin
				$error("last: expected %0b, got %0b", w.last, last);
				errors++;
			end
			if (bad !== w.bad) begin
				$error("bad_base: expected %0b, got %0b", w.bad, bad);
				errors++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit quiet = 1'b0;
	int rx_hold_left = 0;
	digit_scoreboard sb = new();

	itar_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) num_if ();
	itar_out_if chr_if ();

	integer_to_ascii_radix #(.VALUE_WIDTH(VALUE_WIDTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.chr    (chr_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one number; random gaps go in front of it unless in a quiet stretch.
	task automatic send_number(input logic signed [VALUE_WIDTH-1:0] v,
			input logic [BASE_W-1:0] b);
		if (!quiet) begin
			while ($urandom_range(99) < 32) begin
				num_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		num_if.valid <= 1'b1;
		num_if.value <= v;
		num_if.base <= b;
		do @(posedge clk); while (!num_if.ready);
		sb.note_number(v, b);
	endtask

	// Character side: check accepted words, then pick ready for the next cycle.
	initial begin
		chr_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && chr_if.valid && chr_if.ready) begin
				sb.check_char(chr_if.digit_char, chr_if.last, chr_if.bad_base);
			end
			if (rx_hold_left > 0) begin
				chr_if.ready <= 1'b0;
				rx_hold_left--;
			end else begin
				chr_if.ready <= quiet || ($urandom_range(99) >= 32);
			end
		end
	end

	initial begin
		logic signed [VALUE_WIDTH-1:0] dir_values[24];
		logic [BASE_W-1:0] dir_bases[24];
		logic signed [VALUE_WIDTH-1:0] v;
		logic [BASE_W-1:0] b;
		int sel;
		num_if.valid <= 1'b0;
		num_if.value <= '0;
		num_if.base <= '0;

		dir_values = '{0, 0, 1, -1, -1, -1, INT_MIN, INT_MIN, INT_MAX, INT_MAX,
			-INT_MAX, 35, 10, 12345, 12345, 12345, 12345, 123456789, -123, -5,
			9, 255, 0, 0};
		dir_bases = '{10, 2, 2, 10, 2, 16, 10, 2, 10, 36,
			10, 36, 11, 0, 1, 37, 63, 10, 10, 36,
			10, 16, 36, 37};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_values[i]) begin
			send_number(dir_values[i], dir_bases[i]);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 100 && n < 160);
			// long stall on the character side while numbers keep coming
			if (n == 180) begin
				rx_hold_left = HOLD_CYCLES;
			end
			// let the block drain completely before going on
			if (n == 240) begin
				num_if.valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			sel = $urandom_range(9);
			case (sel)
				5: v = $urandom_range(100);
				6: v = -$signed($urandom_range(100, 1));
				7: begin
					case ($urandom_range(4))
						0: v = 0;
						1: v = -1;
						2: v = INT_MIN;
						3: v = INT_MAX;
						default: v = INT_MIN + 1;
					endcase
				end
				8: v = $urandom >> $urandom_range(31);
				9: v = -$signed($urandom >> $urandom_range(31));
				default: v = $urandom;
			endcase
			sel = $urandom_range(99);
			if (sel < 8) begin
				b = $urandom_range(1) ? BASE_W'($urandom_range(1)) : BASE_W'($urandom_range(63, 37));
			end else if (sel < 25) begin
				b = BASE_DEC;
			end else begin
				b = BASE_W'($urandom_range(36, 2));
			end
			send_number(v, b);
		end
		num_if.valid <= 1'b0;
		quiet = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/itar_pkg.sv
hw/rtl/itar_in_if.sv
hw/rtl/itar_out_if.sv
hw/rtl/itar_divider.sv
hw/rtl/itar_digit_buf.sv
hw/rtl/integer_to_ascii_radix.sv
dv/tb.sv
